[rtl/tlms_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the TileLink-UL memory slave.
package tlms_pkg;

   localparam int BEAT_BYTES        = 16;
   localparam int LANE_W            = $clog2(BEAT_BYTES);
   localparam int BYTE_W            = 8;
   localparam int MAX_BEATS         = 64;
   localparam int MEM_BYTES_DEF     = 65536;
   localparam int MAX_SIZE_LOG2_DEF = 10;

   // channel A opcodes
   localparam logic [2:0] OP_PUT_FULL    = 3'd0;
   localparam logic [2:0] OP_PUT_PARTIAL = 3'd1;
   localparam logic [2:0] OP_GET         = 3'd4;

   // channel D opcodes
   localparam logic D_ACK      = 1'b0;
   localparam logic D_ACK_DATA = 1'b1;

   typedef struct packed {
      logic [2:0]  a_opcode;
      logic [2:0]  a_param;
      logic [3:0]  a_size;
      logic [7:0]  a_source;
      logic [31:0] a_address;
      logic [15:0] a_mask;
      logic        a_corrupt;
      logic [63:0] a_data_lo;
      logic [63:0] a_data_hi;
   } req_type;

   typedef struct packed {
      logic        d_opcode;
      logic        d_param;
      logic [3:0]  d_size;
      logic [7:0]  d_source;
      logic        d_denied;
      logic        d_corrupt;
      logic [63:0] d_data_lo;
      logic [63:0] d_data_hi;
      logic        d_last;
   } rsp_type;

   // one beat, lane 0 in the low byte
   typedef logic [BEAT_BYTES-1:0][BYTE_W-1:0] beat_type;

   typedef struct packed {
      logic                  wr;
      logic                  rd;
      logic [BEAT_BYTES-1:0] lane_en;
   } mem_ctl_type;

   // index of the lowest set lane, BEAT_BYTES when the mask is empty
   function automatic logic [LANE_W:0] first_lane(input logic [BEAT_BYTES-1:0] mask);
      logic [LANE_W:0] idx;
      idx = (LANE_W + 1)'(BEAT_BYTES);
      for (int i = BEAT_BYTES - 1; i >= 0; i--) begin
         if (mask[i]) begin
            idx = (LANE_W + 1)'(i);
         end
      end
      return idx;
   endfunction

endpackage

[rtl/tlms_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module tlms_ram #(
   parameter int WIDTH = tlms_pkg::BYTE_W,
   parameter int DEPTH = tlms_pkg::MEM_BYTES_DEF / tlms_pkg::BEAT_BYTES
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tlms_bank_array.sv]
`timescale 1ns / 1ps
// Sixteen byte-wide banks with lane rotation for unaligned beat access.
module tlms_bank_array #(
   parameter int MEM_BYTES = tlms_pkg::MEM_BYTES_DEF
) (
   input  logic                         clock,
   input  tlms_pkg::mem_ctl_type        mem_ctl,
   input  logic [$clog2(MEM_BYTES)-1:0] mem_addr,
   input  tlms_pkg::beat_type           wr_beat,
   output tlms_pkg::beat_type           rd_beat
);
   import tlms_pkg::*;

   localparam int ROWS = MEM_BYTES / BEAT_BYTES;
   localparam int RW   = $clog2(ROWS);
   localparam int AW   = $clog2(MEM_BYTES);

   logic [LANE_W-1:0]                 base_lo;
   logic [RW-1:0]                     base_row;
   logic [RW-1:0]                     row_up;
   logic [BEAT_BYTES-1:0][LANE_W-1:0] bank_lane;
   logic [BEAT_BYTES-1:0][RW-1:0]     bank_row;
   beat_type                          bank_q;
   logic [LANE_W-1:0]                 rot_ff;

   assign base_lo  = mem_addr[LANE_W-1:0];
   assign base_row = mem_addr[AW-1:LANE_W];
   assign row_up   = base_row + RW'(1);

   // bank j holds the lane that lands on it; banks below the start bank sit one row up
   genvar j;
   generate
      for (j = 0; j < BEAT_BYTES; j++) begin : g_bank
         assign bank_lane[j] = LANE_W'(j) - base_lo;
         assign bank_row[j]  = (LANE_W'(j) < base_lo) ? row_up : base_row;

         tlms_ram #(
            .WIDTH(BYTE_W),
            .DEPTH(ROWS)
         ) u_ram (
            .clock  (clock),
            .wr_en  (mem_ctl.wr && mem_ctl.lane_en[bank_lane[j]]),
            .wr_addr(bank_row[j]),
            .wr_data(wr_beat[bank_lane[j]]),
            .rd_en  (mem_ctl.rd),
            .rd_addr(bank_row[j]),
            .rd_data(bank_q[j])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (mem_ctl.rd) begin
         rot_ff <= base_lo;
      end
   end

   // rotate read banks back into lane order
   always_comb begin
      for (int l = 0; l < BEAT_BYTES; l++) begin
         rd_beat[l] = bank_q[LANE_W'(l) + rot_ff];
      end
   end

endmodule

[rtl/tilelink_ul_memory_slave.sv]
`timescale 1ns / 1ps
// Top level: channel A decode, burst control and channel D response register.
//
// TileLink-UL memory slave over a banked byte memory of MEM_BYTES bytes.
// Channel A: one 16-byte beat is taken at each rising edge with start high
// and busy low; the beat travels in req_data.
// Channel D: each response beat sits on rsp_data for one cycle with
// rsp_strobe high. The receiver cannot stall, so no back pressure exists.
// Put beats (full or partial) are written in the cycle they are accepted,
// one beat per cycle; busy stays low during a put burst. The AccessAck shows
// up in the cycle after the final beat is accepted.
// A get of n response beats (n up to 64) keeps busy high from acceptance
// while it issues one bank read per beat, and on until the registered read
// of the last beat is done. The first data beat passes the bank read
// register and the response register in turn; beats follow one per cycle.
// After reset a clearing pass zeroes the memory, one row of 16 bytes a cycle,
// with busy held high. Dropped messages produce no response.
module tilelink_ul_memory_slave #(
   parameter int MEM_BYTES     = tlms_pkg::MEM_BYTES_DEF,
   parameter int MAX_SIZE_LOG2 = tlms_pkg::MAX_SIZE_LOG2_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tlms_pkg::req_type req_data,
   output logic              rsp_strobe,
   output tlms_pkg::rsp_type rsp_data
);
   import tlms_pkg::*;

   localparam int AW   = $clog2(MEM_BYTES);
   localparam int ROWS = MEM_BYTES / BEAT_BYTES;
   localparam int RW   = $clog2(ROWS);
   localparam int EW   = MAX_SIZE_LOG2 + 1;
   localparam int PW   = EW + 1;
   localparam int GBW  = $clog2(MAX_BEATS);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_PUT   = 2'd2;
   localparam logic [1:0] ST_GET   = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [RW-1:0]         clr_ff, clr_in;
   logic                  partial_ff, partial_in;
   logic [EW-1:0]         endp_ff, endp_in;
   logic [EW-1:0]         pos_ff, pos_in;
   logic [31:0]           addr_ff, addr_in;
   logic [3:0]            size_ff, size_in;
   logic [7:0]            source_ff, source_in;
   logic [LANE_W-1:0]     start_ff, start_in;
   logic [GBW-1:0]        gbeat_ff, gbeat_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [BEAT_BYTES-1:0] rd_en_ff, rd_en_in;
   logic                  rd_last_ff, rd_last_in;
   logic [3:0]            rd_size_ff, rd_size_in;
   logic [7:0]            rd_source_ff, rd_source_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;

   logic                  accept;
   logic [LANE_W:0]       s_lane;
   logic                  mask_empty;
   logic [31:0]           align_mask;
   logic                  bad_msg;
   logic                  put_abort;
   logic [EW-1:0]         req_total;
   logic [31:0]           ctx_addr;
   logic [EW-1:0]         ctx_pos;
   logic [EW-1:0]         ctx_endp;
   logic [LANE_W-1:0]     ctx_lo;
   logic                  ctx_partial;
   logic [3:0]            ctx_size;
   logic [7:0]            ctx_source;
   logic [31:0]           ctx_base;
   logic [BEAT_BYTES-1:0] lane_in;
   logic [BEAT_BYTES-1:0] put_lanes;
   logic                  beat_done;
   logic [PW-1:0]         lane_pos;
   mem_ctl_type           mem_ctl;
   logic [AW-1:0]         mem_addr;
   beat_type              wr_beat;
   beat_type              rd_beat;
   beat_type              out_beat;

   assign busy   = (state_ff == ST_CLEAR) || (state_ff == ST_GET) || rd_valid_ff;
   assign accept = start && !busy;

   // decode of the incoming beat
   always_comb begin
      s_lane     = first_lane(req_data.a_mask);
      mask_empty = s_lane[LANE_W];
      align_mask = (32'd1 << req_data.a_size) - 32'd1;
      bad_msg    = (req_data.a_param != 3'd0) || req_data.a_corrupt ||
                   (req_data.a_size > 4'(MAX_SIZE_LOG2)) ||
                   ((req_data.a_address & align_mask) != 32'd0);
      put_abort  = (req_data.a_param != 3'd0) || req_data.a_corrupt ||
                   (!partial_ff && !req_data.a_mask[0]);
      req_total  = EW'(1) << req_data.a_size;
   end

   // beat context: fresh request when idle, stored burst otherwise
   always_comb begin
      if (state_ff == ST_IDLE) begin
         ctx_addr    = req_data.a_address;
         ctx_pos     = '0;
         ctx_lo      = (req_data.a_opcode == OP_PUT_PARTIAL) ? '0 : s_lane[LANE_W-1:0];
         ctx_endp    = EW'(ctx_lo) + req_total;
         ctx_partial = (req_data.a_opcode == OP_PUT_PARTIAL);
         ctx_size    = req_data.a_size;
         ctx_source  = req_data.a_source;
      end else begin
         ctx_addr    = addr_ff;
         ctx_pos     = pos_ff;
         ctx_lo      = (pos_ff == '0) ? start_ff : '0;
         ctx_endp    = endp_ff;
         ctx_partial = partial_ff;
         ctx_size    = size_ff;
         ctx_source  = source_ff;
      end
      ctx_base  = ctx_addr + 32'(ctx_pos);
      lane_pos  = '0;
      for (int l = 0; l < BEAT_BYTES; l++) begin
         lane_pos   = {1'b0, ctx_pos} + PW'(l);
         lane_in[l] = (LANE_W'(l) >= ctx_lo) && (lane_pos < {1'b0, ctx_endp});
      end
      beat_done = ({1'b0, ctx_pos} + PW'(BEAT_BYTES)) >= {1'b0, ctx_endp};
      put_lanes = lane_in & (ctx_partial ? req_data.a_mask : '1);
   end

   // mask unfilled lanes of the returning read
   always_comb begin
      for (int l = 0; l < BEAT_BYTES; l++) begin
         out_beat[l] = rd_en_ff[l] ? rd_beat[l] : '0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      partial_in    = partial_ff;
      endp_in       = endp_ff;
      pos_in        = pos_ff;
      addr_in       = addr_ff;
      size_in       = size_ff;
      source_in     = source_ff;
      start_in      = start_ff;
      gbeat_in      = gbeat_ff;
      rd_valid_in   = 1'b0;
      rd_en_in      = rd_en_ff;
      rd_last_in    = rd_last_ff;
      rd_size_in    = rd_size_ff;
      rd_source_in  = rd_source_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      mem_ctl       = '0;
      mem_addr      = ctx_base[AW-1:0];
      wr_beat       = {req_data.a_data_hi, req_data.a_data_lo};

      case (state_ff)
         ST_CLEAR: begin
            mem_addr        = {clr_ff, {LANE_W{1'b0}}};
            mem_ctl.wr      = 1'b1;
            mem_ctl.lane_en = '1;
            wr_beat         = '0;
            clr_in          = clr_ff + RW'(1);
            if (clr_ff == RW'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && !bad_msg) begin
               addr_in   = req_data.a_address;
               size_in   = req_data.a_size;
               source_in = req_data.a_source;
               start_in  = ctx_lo;
               endp_in   = ctx_endp;
               if (req_data.a_opcode == OP_GET && !mask_empty) begin
                  pos_in   = '0;
                  gbeat_in = '0;
                  state_in = ST_GET;
               end else if ((req_data.a_opcode == OP_PUT_FULL && !mask_empty) ||
                            req_data.a_opcode == OP_PUT_PARTIAL) begin
                  mem_ctl.wr      = 1'b1;
                  mem_ctl.lane_en = put_lanes;
                  partial_in      = ctx_partial;
                  pos_in          = ctx_pos + EW'(BEAT_BYTES);
                  if (beat_done) begin
                     rsp_strobe_in = 1'b1;
                  end else begin
                     state_in = ST_PUT;
                  end
               end
            end
         end
         ST_PUT: begin
            if (accept) begin
               if (put_abort) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_ctl.wr      = 1'b1;
                  mem_ctl.lane_en = put_lanes;
                  pos_in          = ctx_pos + EW'(BEAT_BYTES);
                  if (beat_done) begin
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
            end
         end
         ST_GET: begin
            mem_ctl.rd   = 1'b1;
            rd_valid_in  = 1'b1;
            rd_en_in     = lane_in;
            rd_last_in   = beat_done || (gbeat_ff == GBW'(MAX_BEATS - 1));
            rd_size_in   = size_ff;
            rd_source_in = source_ff;
            pos_in       = ctx_pos + EW'(BEAT_BYTES);
            gbeat_in     = gbeat_ff + GBW'(1);
            if (rd_last_in) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // put ack; busy keeps it apart from a returning read beat
      if (rsp_strobe_in) begin
         rsp_in.d_opcode = D_ACK;
         rsp_in.d_size   = ctx_size;
         rsp_in.d_source = ctx_source;
         rsp_in.d_last   = 1'b1;
      end

      if (rd_valid_ff) begin
         rsp_strobe_in    = 1'b1;
         rsp_in.d_opcode  = D_ACK_DATA;
         rsp_in.d_size    = rd_size_ff;
         rsp_in.d_source  = rd_source_ff;
         rsp_in.d_data_lo = out_beat[7:0];
         rsp_in.d_data_hi = out_beat[15:8];
         rsp_in.d_last    = rd_last_ff;
      end
   end

   tlms_bank_array #(
      .MEM_BYTES(MEM_BYTES)
   ) u_banks (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .mem_addr(mem_addr),
      .wr_beat (wr_beat),
      .rd_beat (rd_beat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      partial_ff   <= partial_in;
      endp_ff      <= endp_in;
      pos_ff       <= pos_in;
      addr_ff      <= addr_in;
      size_ff      <= size_in;
      source_ff    <= source_in;
      start_ff     <= start_in;
      gbeat_ff     <= gbeat_in;
      rd_en_ff     <= rd_en_in;
      rd_last_ff   <= rd_last_in;
      rd_size_ff   <= rd_size_in;
      rd_source_ff <= rd_source_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef NO_ASSERTIONS
   a_ack_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.d_opcode == D_ACK) |-> rsp_data.d_last)
      else $error("AccessAck without last mark");

   a_ack_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.d_opcode == D_ACK) |-> $past(start && !busy))
      else $error("AccessAck not preceded by an accepted put transfer");

   a_read_returns: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |=> (rsp_strobe && rsp_data.d_opcode == D_ACK_DATA))
      else $error("read beat did not reach the response register");

   a_get_issues_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GET) |=> rd_valid_ff)
      else $error("get state without a bank read in flight");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.wr && mem_ctl.rd))
      else $error("bank write and read issued together");
`endif

endmodule
